@@ sv/bba_pkg.sv @@
// Shared types and codes for the bitmap block allocator.
package bba_pkg;

  localparam int OPW  = 3;
  localparam int IDXW = 12;
  localparam int LENW = 13;
  localparam int CNTW = 13;
  localparam int ENDW = 14;

  localparam logic [OPW-1:0] OP_CLEAR_ALL   = 3'd0;
  localparam logic [OPW-1:0] OP_FIND_FREE   = 3'd1;
  localparam logic [OPW-1:0] OP_COUNT_RANGE = 3'd2;
  localparam logic [OPW-1:0] OP_ENOUGH_FREE = 3'd3;
  localparam logic [OPW-1:0] OP_RANGE_FREE  = 3'd4;
  localparam logic [OPW-1:0] OP_SET_RANGE   = 3'd5;
  localparam logic [OPW-1:0] OP_CLEAR_RANGE = 3'd6;

  localparam logic [CNTW-1:0] BLOCK_COUNT_RST = 13'd4096;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DISP,
    ST_CLEAR,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN
  } bba_state_t;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic issue;
    logic out_load;
  } bba_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic skip;
    logic addr_last;
    logic issue_last;
    logic busy;
  } bba_sts_t;

endpackage

@@ sv/block_bitmap_allocator.sv @@
// Bitmap block allocator, first fit: one request at a time over a word-wide bitmap memory.
// Scan and range ops walk the bitmap words up to the range end (the volume end for find
// and enough-free), at most ceil(MAX_BLOCKS/WORD_BITS) words; clear_all clears all words;
// out-of-range and unused ops go straight to the result. Next accept can come in the cycle
// after the result load. The bitmap memory, with one write and one registered read port,
// is walked one word per cycle. Reset sweeps all words clear with input stalled.
module block_bitmap_allocator import bba_pkg::*; #(
  parameter int MAX_BLOCKS = 4096,
  parameter int WORD_BITS  = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [CNTW-1:0] cfg_data,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [OPW-1:0]  in_op,
  input  logic [IDXW-1:0] in_start_block,
  input  logic [LENW-1:0] in_length_blocks,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [IDXW-1:0] out_found_index,
  output logic            out_found,
  output logic [CNTW-1:0] out_free_count,
  output logic            out_answer,
  output logic            out_status
);

  bba_cmd_t cmd;
  bba_sts_t sts;

  assign cfg_ready = 1'b1;

  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  bba_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .WORD_BITS  (WORD_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_valid & cfg_ready),
    .cfg_data         (cfg_data),
    .in_op            (in_op),
    .in_start_block   (in_start_block),
    .in_length_blocks (in_length_blocks),
    .cmd              (cmd),
    .sts              (sts),
    .out_found_index  (out_found_index),
    .out_found        (out_found),
    .out_free_count   (out_free_count),
    .out_answer       (out_answer),
    .out_status       (out_status)
  );

`ifndef SYNTH
  // one request in flight: an accepted beat blocks the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while a request is in flight");

  a_oor_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> !out_answer && (out_free_count == '0) && !out_found)
    else $error("out-of-range result carries data");

  a_found_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> !out_answer && (out_free_count == '0))
    else $error("find result mixed with count or answer");
`endif

endmodule

@@ sv/bba_datapath.sv @@
// Bitmap store, word scan pipeline, counters and result registers.
module bba_datapath import bba_pkg::*; #(
  parameter int MAX_BLOCKS = 4096,
  parameter int WORD_BITS  = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [CNTW-1:0] cfg_data,
  input  logic [OPW-1:0]  in_op,
  input  logic [IDXW-1:0] in_start_block,
  input  logic [LENW-1:0] in_length_blocks,
  input  bba_cmd_t        cmd,
  output bba_sts_t        sts,
  output logic [IDXW-1:0] out_found_index,
  output logic            out_found,
  output logic [CNTW-1:0] out_free_count,
  output logic            out_answer,
  output logic            out_status
);

  localparam int WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int XW0   = $clog2(WORDS * WORD_BITS + WORD_BITS + 1);
  localparam int XW    = (XW0 > ENDW) ? XW0 : ENDW;
  localparam int NG    = (WORD_BITS + 7) / 8;
  localparam int PW    = $clog2(WORD_BITS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(WORDS - 1);
  localparam logic [31:0]   MAXB      = 32'(MAX_BLOCKS);

  logic [WORD_BITS-1:0] mem [WORDS];
  logic [WORD_BITS-1:0] mem_q;

  logic [CNTW-1:0] block_count_r;
  logic [OPW-1:0]  op_r;
  logic [ENDW-1:0] lo_r, hi_r;
  logic [LENW-1:0] len_r;
  logic            oor_r;
  logic [AW-1:0]   addr_r;
  logic [XW-1:0]   base_r;
  logic            s1_v_r, s2_v_r;
  logic [XW-1:0]   s1_base_r;
  logic [AW-1:0]   s1_addr_r;
  logic [3:0]      grp_r [NG];
  logic [CNTW-1:0] acc_r;
  logic            found_r;
  logic [IDXW-1:0] fidx_r;

  logic [IDXW-1:0] out_found_index_r;
  logic            out_found_r;
  logic [CNTW-1:0] out_free_count_r;
  logic            out_answer_r;
  logic            out_status_r;

  logic [CNTW-1:0]      cnt_w;
  logic [ENDW-1:0]      end_w;
  logic                 is_range_w;
  logic [WORD_BITS-1:0] mask_w, free_w, wdata_w;
  logic                 do_wr_w, hit_w;
  logic [PW-1:0]        pos_w;
  logic [3:0]           grp_w [NG];
  logic [CNTW-1:0]      grp_sum_w;

  // effective volume size
  assign cnt_w = ({19'b0, block_count_r} > MAXB) ? MAXB[CNTW-1:0] : block_count_r;
  assign end_w = ENDW'(in_start_block) + ENDW'(in_length_blocks);
  assign is_range_w = (in_op == OP_COUNT_RANGE) || (in_op == OP_RANGE_FREE) ||
                      (in_op == OP_SET_RANGE) || (in_op == OP_CLEAR_RANGE);

  // per-word mask, free bits, write-back data, first free bit, group counts
  always_comb begin
    logic [XW-1:0]     blk;
    logic [NG*8-1:0]   free_pad;
    mask_w = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      blk = s1_base_r + XW'(j);
      mask_w[j] = (blk >= XW'(lo_r)) && (blk < XW'(hi_r));
    end
    free_w  = ~mem_q & mask_w;
    wdata_w = (op_r == OP_SET_RANGE) ? (mem_q | mask_w) : (mem_q & ~mask_w);
    do_wr_w = s1_v_r && ((op_r == OP_SET_RANGE) || (op_r == OP_CLEAR_RANGE));
    hit_w   = |free_w;
    pos_w   = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (free_w[j]) pos_w = PW'(j);
    end
    free_pad = (NG*8)'(free_w);
    for (int g = 0; g < NG; g++) begin
      grp_w[g] = '0;
      for (int b = 0; b < 8; b++) begin
        grp_w[g] = grp_w[g] + 4'(free_pad[g*8+b]);
      end
    end
  end

  always_comb begin
    grp_sum_w = '0;
    for (int g = 0; g < NG; g++) begin
      grp_sum_w = grp_sum_w + CNTW'(grp_r[g]);
    end
  end

  assign sts.is_clear   = (op_r == OP_CLEAR_ALL);
  assign sts.skip       = oor_r || (op_r > OP_CLEAR_RANGE);
  assign sts.addr_last  = (addr_r == LAST_ADDR);
  assign sts.issue_last = (addr_r == LAST_ADDR) ||
                          ((base_r + XW'(WORD_BITS)) >= XW'(hi_r));
  assign sts.busy       = s1_v_r | s2_v_r;

  // bitmap memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      mem[addr_r] <= '0;
    end else if (do_wr_w) begin
      mem[s1_addr_r] <= wdata_w;
    end
    if (cmd.issue) begin
      mem_q <= mem[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_count_r <= BLOCK_COUNT_RST;
      addr_r        <= '0;
      s1_v_r        <= 1'b0;
      s2_v_r        <= 1'b0;
    end else begin
      if (cfg_we) block_count_r <= cfg_data;
      s1_v_r <= cmd.issue;
      s2_v_r <= s1_v_r;
      if (cmd.load) begin
        addr_r <= '0;
      end else if (cmd.clr_step) begin
        addr_r <= (addr_r == LAST_ADDR) ? '0 : addr_r + 1'b1;
      end else if (cmd.issue) begin
        addr_r <= addr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_op;
      len_r   <= in_length_blocks;
      lo_r    <= is_range_w ? ENDW'(in_start_block) : '0;
      hi_r    <= is_range_w ? end_w : ENDW'(cnt_w);
      oor_r   <= is_range_w && (end_w > ENDW'(cnt_w));
      base_r  <= '0;
      acc_r   <= '0;
      found_r <= 1'b0;
      fidx_r  <= '0;
    end else begin
      if (cmd.issue) base_r <= base_r + XW'(WORD_BITS);
      if (s1_v_r && hit_w && !found_r) begin
        found_r <= 1'b1;
        fidx_r  <= IDXW'(s1_base_r + XW'(pos_w));
      end
      if (s2_v_r) acc_r <= acc_r + grp_sum_w;
    end
    if (cmd.issue) begin
      s1_base_r <= base_r;
      s1_addr_r <= addr_r;
    end
    for (int g = 0; g < NG; g++) begin
      grp_r[g] <= grp_w[g];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_found_index_r <= (op_r == OP_FIND_FREE) ? fidx_r : '0;
      out_found_r       <= (op_r == OP_FIND_FREE) && found_r;
      out_free_count_r  <= (((op_r == OP_COUNT_RANGE) && !oor_r) ||
                            (op_r == OP_ENOUGH_FREE)) ? acc_r : '0;
      out_answer_r      <= ((op_r == OP_ENOUGH_FREE) && (acc_r >= len_r)) ||
                           ((op_r == OP_RANGE_FREE) && !oor_r && (acc_r == len_r));
      out_status_r      <= oor_r;
    end
  end

  assign out_found_index = out_found_index_r;
  assign out_found       = out_found_r;
  assign out_free_count  = out_free_count_r;
  assign out_answer      = out_answer_r;
  assign out_status      = out_status_r;

endmodule

@@ sv/bba_ctrl.sv @@
// Request sequencer: clearing sweep, word scan issue, drain and result handoff.
module bba_ctrl import bba_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output bba_cmd_t cmd,
  input  bba_sts_t sts
);

  bba_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_INIT: begin
        cmd.clr_step = 1'b1;
        if (sts.addr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DISP;
        end
      end
      ST_DISP: begin
        priority if (sts.is_clear) state_nxt = ST_CLEAR;
        else if (sts.skip)         state_nxt = ST_FIN;
        else                       state_nxt = ST_SCAN;
      end
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.addr_last) state_nxt = ST_FIN;
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        if (sts.issue_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!sts.busy) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // result register must be free before it is overwritten
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ tb/tb.sv @@
// Testbench for block_bitmap_allocator: directed and random requests against a bitmap model.
module tb;
  import bba_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_BLK = 4096;
  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 200;
  localparam logic [OPW-1:0] OP_UNUSED = 3'd7;

  typedef struct packed {
    logic [OPW-1:0]  op;
    logic [IDXW-1:0] start_block;
    logic [LENW-1:0] length_blocks;
  } alloc_req_t;

  typedef struct packed {
    logic [IDXW-1:0] found_index;
    logic            found;
    logic [CNTW-1:0] free_count;
    logic            answer;
    logic            status;
  } alloc_resp_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [CNTW-1:0] cfg_data = '0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  logic [OPW-1:0]  in_op = '0;
  logic [IDXW-1:0] in_start_block = '0;
  logic [LENW-1:0] in_length_blocks = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic [IDXW-1:0] out_found_index;
  logic            out_found;
  logic [CNTW-1:0] out_free_count;
  logic            out_answer;
  logic            out_status;

  // model state
  bit [MAX_BLK-1:0] used_map = '0;
  int unsigned      vol_blocks = BLOCK_COUNT_RST;

  alloc_req_t  req_q[$];
  alloc_resp_t resp_q[$];
  alloc_req_t  next_req;
  alloc_resp_t got_resp;
  alloc_resp_t want_resp;
  int          pending = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  int          idle_cycles = 0;
  int          errors = 0;
  bit          quiet = 1'b0;

  always #6 clk = ~clk;

  block_bitmap_allocator i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_start_block   (in_start_block),
    .in_length_blocks (in_length_blocks),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_found_index  (out_found_index),
    .out_found        (out_found),
    .out_free_count   (out_free_count),
    .out_answer       (out_answer),
    .out_status       (out_status)
  );

  function automatic int eff_blocks();
    return (vol_blocks > MAX_BLK) ? MAX_BLK : int'(vol_blocks);
  endfunction

  function automatic int free_between(int first, int last);
    int n;
    n = 0;
    for (int i = first; i < last; i++) begin
      if (!used_map[i]) n++;
    end
    return n;
  endfunction

  // Applies one request to the bitmap model and returns the response it should produce.
  function automatic alloc_resp_t apply_request(logic [OPW-1:0] op, logic [IDXW-1:0] sb,
                                                logic [LENW-1:0] len);
    alloc_resp_t r;
    int          lim;
    int          stop;
    int          total;
    r = '{default: '0};
    lim = eff_blocks();
    stop = int'(sb) + int'(len);
    case (op)
      OP_CLEAR_ALL: begin
        used_map = '0;
      end
      OP_FIND_FREE: begin
        for (int i = 0; i < lim; i++) begin
          if (!r.found && !used_map[i]) begin
            r.found_index = i[IDXW-1:0];
            r.found = 1'b1;
          end
        end
      end
      OP_ENOUGH_FREE: begin
        total = free_between(0, lim);
        r.free_count = total[CNTW-1:0];
        r.answer = (total >= int'(len));
      end
      OP_COUNT_RANGE, OP_RANGE_FREE, OP_SET_RANGE, OP_CLEAR_RANGE: begin
        if (stop > lim) begin
          r.status = 1'b1;
        end else if (op == OP_COUNT_RANGE) begin
          total = free_between(sb, stop);
          r.free_count = total[CNTW-1:0];
        end else if (op == OP_RANGE_FREE) begin
          r.answer = (free_between(sb, stop) == int'(len));
        end else begin
          for (int i = sb; i < stop; i++) used_map[i] = (op == OP_SET_RANGE);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Input driver: presents queued requests, predicts each one on acceptance.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      resp_q.push_back(apply_request(in_op, in_start_block, in_length_blocks));
      pending--;
    end
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (req_q.size() != 0 && !quiet && $urandom_range(0, 3) == 0) begin
        gap_left <= $urandom_range(0, 6);
        in_valid <= 1'b0;
      end else if (req_q.size() != 0) begin
        next_req = req_q.pop_front();
        in_op <= next_req.op;
        in_start_block <= next_req.start_block;
        in_length_blocks <= next_req.length_blocks;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side: random stall bursts, compare each beat with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_resp = '{out_found_index, out_found, out_free_count, out_answer, out_status};
      if (resp_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected result beat idx=%0d found=%0b cnt=%0d ans=%0b st=%0b",
                   $realtime, got_resp.found_index, got_resp.found, got_resp.free_count,
                   got_resp.answer, got_resp.status);
      end else begin
        want_resp = resp_q.pop_front();
        if (got_resp !== want_resp) begin
          errors++;
          if (errors <= 10)
            $display({"%0t: mismatch exp idx=%0d found=%0b cnt=%0d ans=%0b st=%0b,",
                      " got idx=%0d found=%0b cnt=%0d ans=%0b st=%0b"},
                     $realtime, want_resp.found_index, want_resp.found, want_resp.free_count,
                     want_resp.answer, want_resp.status, got_resp.found_index, got_resp.found,
                     got_resp.free_count, got_resp.answer, got_resp.status);
        end
      end
    end
    if (quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(input logic [OPW-1:0] op, input int sb, input int len);
    alloc_req_t r;
    r.op = op;
    r.start_block = sb[IDXW-1:0];
    r.length_blocks = len[LENW-1:0];
    req_q.push_back(r);
    pending++;
    while (req_q.size() > 2) @(posedge clk);
  endtask

  task automatic wait_idle();
    while (pending != 0 || resp_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_block_count(input int value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= value[CNTW-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    vol_blocks = value & 'h1FFF;
    cfg_valid <= 1'b0;
  endtask

  task automatic test_basic_ops();
    send_item(OP_FIND_FREE, 0, 0);
    send_item(OP_ENOUGH_FREE, 0, 4096);
    send_item(OP_SET_RANGE, 0, 4096);
    send_item(OP_FIND_FREE, 0, 0);             // full store: nothing found
    send_item(OP_COUNT_RANGE, 4095, 1);
    send_item(OP_RANGE_FREE, 0, 0);            // empty range is free
    send_item(OP_ENOUGH_FREE, 4095, 1);
    send_item(OP_CLEAR_RANGE, 4095, 1);
    send_item(OP_FIND_FREE, 0, 0);
    send_item(OP_SET_RANGE, 4095, 2);          // one past the end
    send_item(OP_COUNT_RANGE, 4095, 8191);
    send_item(OP_UNUSED, 4095, 8191);
    send_item(OP_CLEAR_ALL, 0, 0);
    send_item(OP_RANGE_FREE, 100, 50);
    send_item(OP_SET_RANGE, 120, 1);
    send_item(OP_RANGE_FREE, 100, 50);
    send_item(OP_COUNT_RANGE, 100, 50);
    send_item(OP_CLEAR_RANGE, 120, 0);
  endtask

  task automatic test_block_count_edges();
    write_block_count(0);
    send_item(OP_FIND_FREE, 0, 0);
    send_item(OP_ENOUGH_FREE, 0, 0);
    send_item(OP_RANGE_FREE, 0, 0);
    send_item(OP_SET_RANGE, 0, 1);
    write_block_count(1);
    send_item(OP_SET_RANGE, 0, 1);
    send_item(OP_FIND_FREE, 0, 0);
    send_item(OP_ENOUGH_FREE, 0, 1);
    // clear_all must also wipe blocks past the volume end
    write_block_count(8191);
    send_item(OP_SET_RANGE, 2048, 2048);
    write_block_count(32);
    send_item(OP_CLEAR_ALL, 0, 0);
    write_block_count(4096);
    send_item(OP_ENOUGH_FREE, 0, 4096);
  endtask

  function automatic alloc_req_t random_request();
    alloc_req_t r;
    int         lim;
    int         k;
    int         sb;
    int         len;
    lim = eff_blocks();
    k = $urandom_range(0, 99);
    if (k < 8) begin
      r.op = OPW'($urandom_range(0, 7));
      r.start_block = IDXW'($urandom);
      r.length_blocks = LENW'($urandom);
      return r;
    end
    k = $urandom_range(0, 99);
    if (k < 2) r.op = OP_CLEAR_ALL;
    else if (k < 14) r.op = OP_FIND_FREE;
    else if (k < 28) r.op = OP_COUNT_RANGE;
    else if (k < 40) r.op = OP_ENOUGH_FREE;
    else if (k < 56) r.op = OP_RANGE_FREE;
    else if (k < 77) r.op = OP_SET_RANGE;
    else if (k < 98) r.op = OP_CLEAR_RANGE;
    else r.op = OP_UNUSED;
    if (lim == 0) len = 0;
    else if ($urandom_range(0, 9) == 0) len = $urandom_range(0, lim);
    else len = $urandom_range(0, (lim < 48) ? lim : 48);
    sb = $urandom_range(0, lim - len);
    if (sb > MAX_BLK - 1) sb = MAX_BLK - 1;
    if ($urandom_range(0, 9) == 0) begin
      // range just past the volume end
      sb = $urandom_range(0, (lim < MAX_BLK) ? lim : MAX_BLK - 1);
      len = lim - sb + $urandom_range(1, 8);
    end
    if (r.op == OP_ENOUGH_FREE) len = $urandom_range(0, lim + 2);
    r.start_block = sb[IDXW-1:0];
    r.length_blocks = len[LENW-1:0];
    return r;
  endfunction

  task automatic test_random_traffic(input int count_value, input int n_items);
    alloc_req_t r;
    write_block_count(count_value);
    for (int i = 0; i < n_items; i++) begin
      r = random_request();
      send_item(r.op, r.start_block, r.length_blocks);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_ops();
    test_block_count_edges();
    test_random_traffic(4096, 110);
    test_random_traffic($urandom_range(1, 4095), 90);
    test_random_traffic(64, 70);
    test_random_traffic(8191, 40);
    wait_idle();
    quiet = 1'b1;
    test_random_traffic(4096, 90);
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
